// File: rtl/rme_pkg.sv
`timescale 1ns / 1ps
package rme_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 18;
   localparam int SQRT_STEPS    = 32;
   // S0, S1, square root steps, pre-rotation, CORDIC stages
   localparam int NUM_STAGES    = 2 + SQRT_STEPS + 1 + CORDIC_STAGES;

   localparam logic signed [39:0] PI_Q32     = 40'sd13493037705;
   localparam logic signed [39:0] TWO_PI_Q32 = 40'sd26986075409;
   localparam logic [16:0]        THR_RESET  = 17'd65470;

   // atan(2^-i) in radians * 2^32
   localparam logic signed [39:0] ATAN_TAB [32] = '{
      40'sd3373259426, 40'sd1991351318, 40'sd1052175346, 40'sd534100635,
      40'sd268086748, 40'sd134174063, 40'sd67103403, 40'sd33553749,
      40'sd16777131, 40'sd8388597, 40'sd4194303, 40'sd2097152,
      40'sd1048576, 40'sd524288, 40'sd262144, 40'sd131072,
      40'sd65536, 40'sd32768, 40'sd16384, 40'sd8192,
      40'sd4096, 40'sd2048, 40'sd1024, 40'sd512,
      40'sd256, 40'sd128, 40'sd64, 40'sd32,
      40'sd16, 40'sd8, 40'sd4, 40'sd2
   };

   // operands that ride along with the square root
   typedef struct packed {
      logic signed [17:0] ry;
      logic signed [17:0] rx;
      logic signed [18:0] hy;
      logic signed [18:0] hx;
      logic signed [18:0] py;
      logic               hpi;
   } side_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] res;
      side_type    side;
   } sqrt_type;

   typedef struct packed {
      logic signed [47:0] x;
      logic signed [47:0] y;
      logic signed [39:0] z;
      logic               done;
   } lane_type;

   // quadrant fold ahead of the vectoring iterations
   function automatic lane_type cordic_pre(input logic signed [47:0] y,
                                           input logic signed [47:0] x,
                                           input logic signed [39:0] z0);
      lane_type l;
      l.x    = x;
      l.y    = y;
      l.z    = z0;
      l.done = 1'b0;
      if (y == 48'sd0) begin
         l.done = 1'b1;
         if (x < 48'sd0) l.z = z0 + PI_Q32;
      end else if (x < 48'sd0) begin
         l.z = (y > 48'sd0) ? z0 + PI_Q32 : z0 - PI_Q32;
         l.x = -x;
         l.y = -y;
      end
      return l;
   endfunction

   // optional wrap by 2*pi, then round half up to FRAC_BITS
   function automatic logic signed [39:0] round_z(input logic signed [39:0] z,
                                                  input logic wrap);
      logic signed [39:0] a;
      a = 40'sd1 <<< (31 - FRAC_BITS);
      if (wrap && z < 40'sd0) a = a + TWO_PI_Q32;
      return (z + a) >>> (32 - FRAC_BITS);
   endfunction

endpackage

// File: rtl/rme_req_if.sv
`timescale 1ns / 1ps
interface rme_req_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] r00;
   logic signed [17:0] r01;
   logic signed [17:0] r02;
   logic signed [17:0] r10;
   logic signed [17:0] r11;
   logic signed [17:0] r12;
   logic signed [17:0] r20;
   logic signed [17:0] r21;
   logic signed [17:0] r22;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   input ready);
   modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                 output ready);
endinterface

// File: rtl/rme_rsp_if.sv
`timescale 1ns / 1ps
interface rme_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [18:0] roll;
   logic signed [17:0] pitch;
   logic [18:0]        heading;

   modport source (output valid, roll, pitch, heading, input ready);
   modport sink (input valid, roll, pitch, heading, output ready);
endinterface

// File: rtl/rotation_matrix_to_euler_top.sv
`timescale 1ns / 1ps
// Converts a 3x3 direction cosine matrix (Q1.16) to roll, pitch and heading in
// radians (roll Q2.16, pitch Q1.16, heading UQ3.16), ZYX order, heading
// wrapped to 0..2*pi. A new matrix is taken every clock unless rsp stalls.
// The pipeline holds the squares and radicand stages, the 32-step square root
// chain feeding pitch, one pre-rotation stage and 18 CORDIC cells per angle lane
// (three lanes side by side), plus the output register. When rsp is held off the
// whole chain stalls; req_ch.ready drops only then.
module rotation_matrix_to_euler_top (
   input  logic        clock,
   input  logic        reset,
   rme_req_if.sink     req_ch,
   rme_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);
   import rme_pkg::*;

   logic              adv;
   logic [16:0]       thr_ff;
   logic [NUM_STAGES-1:0] vld_ff, vld_in;

   // gimbal threshold register
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= THR_RESET;
      else if (csr_we) thr_ff <= csr_wdata;
   end

   // whole chain moves when the output register can take data
   assign adv          = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   // stage 0: squares, operand select
   logic [35:0]        sq21_ff, sq22_ff;
   side_type           s0_ff, s0_in;
   logic signed [35:0] p21, p22;
   logic signed [18:0] r20w, thrw;

   always_comb begin
      p21  = req_ch.r21 * req_ch.r21;
      p22  = req_ch.r22 * req_ch.r22;
      r20w = 19'(req_ch.r20);
      thrw = {2'b00, thr_ff};
      s0_in.ry  = req_ch.r21;
      s0_in.rx  = req_ch.r22;
      s0_in.py  = -r20w;
      s0_in.hpi = 1'b0;
      if (r20w <= -thrw) begin
         s0_in.hy = 19'(req_ch.r12) - 19'(req_ch.r01);
         s0_in.hx = 19'(req_ch.r02) + 19'(req_ch.r11);
      end else if (r20w >= thrw) begin
         s0_in.hy  = 19'(req_ch.r12) + 19'(req_ch.r01);
         s0_in.hx  = 19'(req_ch.r02) - 19'(req_ch.r11);
         s0_in.hpi = 1'b1;
      end else begin
         s0_in.hy = 19'(req_ch.r10);
         s0_in.hx = 19'(req_ch.r00);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq21_ff <= p21;
         sq22_ff <= p22;
         s0_ff   <= s0_in;
      end
   end

   // stage 1: radicand
   sqrt_type s1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff.rem  <= {27'd0, 37'({1'b0, sq21_ff} + {1'b0, sq22_ff})} << 26;
         s1_ff.res  <= 64'd0;
         s1_ff.side <= s0_ff;
      end
   end

   // square root chain
   sqrt_type sq [SQRT_STEPS+1];
   assign sq[0] = s1_ff;
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      rme_sqrt_cell u_cell (
         .clock (clock),
         .en    (adv),
         .step  (5'(k)),
         .d_in  (sq[k]),
         .d_out (sq[k+1])
      );
   end

   // pre-rotation of the three lanes
   lane_type ln [CORDIC_STAGES+1][3];
   lane_type pre_ff [3];
   side_type sd;
   assign sd = sq[SQRT_STEPS].side;

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_ff[0] <= cordic_pre(48'(sd.ry) <<< 24, 48'(sd.rx) <<< 24, 40'sd0);
         pre_ff[1] <= cordic_pre(48'(sd.py) <<< 13, 48'(sq[SQRT_STEPS].res),
                                 40'sd0);
         pre_ff[2] <= cordic_pre(48'(sd.hy) <<< 24, 48'(sd.hx) <<< 24,
                                 sd.hpi ? PI_Q32 : 40'sd0);
      end
   end

   // CORDIC cells, one per lane per stage
   for (genvar j = 0; j < 3; j++) begin : g_lane
      assign ln[0][j] = pre_ff[j];
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
         rme_cordic_cell u_cell (
            .clock (clock),
            .en    (adv),
            .step  (5'(i)),
            .d_in  (ln[i][j]),
            .d_out (ln[i+1][j])
         );
      end
   end

   // valid chain
   assign vld_in = {vld_ff[NUM_STAGES-2:0], req_ch.valid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   // output register
   logic               rsp_valid_ff;
   logic signed [18:0] roll_ff;
   logic signed [17:0] pitch_ff;
   logic [18:0]        heading_ff;
   logic signed [39:0] roll_r, pitch_r, head_r;

   assign roll_r  = round_z(ln[CORDIC_STAGES][0].z, 1'b0);
   assign pitch_r = round_z(ln[CORDIC_STAGES][1].z, 1'b0);
   assign head_r  = round_z(ln[CORDIC_STAGES][2].z, 1'b1);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= vld_ff[NUM_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff    <= roll_r[18:0];
         pitch_ff   <= pitch_r[17:0];
         heading_ff <= head_r[18:0];
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.roll    = roll_ff;
   assign rsp_ch.pitch   = pitch_ff;
   assign rsp_ch.heading = heading_ff;

   // checks
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff)) else $error("chain moved during stall");
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[0])
      else $error("accepted transaction lost");
   a_drain_taken: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_ch.ready))
      else $error("result dropped without being taken");
endmodule

// File: rtl/rme_sqrt_cell.sv
`timescale 1ns / 1ps
module rme_sqrt_cell (
   input  logic              clock,
   input  logic              en,
   input  logic [4:0]        step,
   input  rme_pkg::sqrt_type d_in,
   output rme_pkg::sqrt_type d_out
);
   import rme_pkg::*;

   sqrt_type    q_ff, q_in;
   logic [5:0]  sh;
   logic [63:0] b, t;

   // one result bit of the floor square root
   always_comb begin
      sh   = 6'd62 - {step, 1'b0};
      b    = 64'd1 << sh;
      t    = d_in.res + b;
      q_in = d_in;
      if (d_in.rem >= t) begin
         q_in.rem = d_in.rem - t;
         q_in.res = (d_in.res >> 1) + b;
      end else begin
         q_in.res = d_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;
endmodule

// File: rtl/rme_cordic_cell.sv
`timescale 1ns / 1ps
module rme_cordic_cell (
   input  logic              clock,
   input  logic              en,
   input  logic [4:0]        step,
   input  rme_pkg::lane_type d_in,
   output rme_pkg::lane_type d_out
);
   import rme_pkg::*;

   lane_type           q_ff, q_in;
   logic signed [47:0] xs, ys;

   // one vectoring micro-rotation
   always_comb begin
      xs   = d_in.x >>> step;
      ys   = d_in.y >>> step;
      q_in = d_in;
      if (!d_in.done) begin
         if (d_in.y >= 48'sd0) begin
            q_in.x = d_in.x + ys;
            q_in.y = d_in.y - xs;
            q_in.z = d_in.z + ATAN_TAB[step];
         end else begin
            q_in.x = d_in.x - ys;
            q_in.y = d_in.y + xs;
            q_in.z = d_in.z - ATAN_TAB[step];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;
endmodule
